@@ design/stt_pkg.sv @@
// Shared constants for the two-phase staircase tracker.
// No dependencies; every other design file refers to this package by scoped names.
package stt_pkg;

	// Default stimulus width, Q8.8
	localparam int STIMULUS_BITS_DEF = 16;
	// Step registers and reversal counters have fixed widths
	localparam int STEP_BITS         = 16;
	localparam int COUNT_BITS        = 8;
	// Configuration port
	localparam int CFG_INDEX_BITS    = 8;
	localparam int CFG_DATA_BITS     = 16;

	// Register reset values
	localparam logic [STEP_BITS-1:0]  COARSE_STEP_RST      = 16'd256;
	localparam logic [STEP_BITS-1:0]  FINE_STEP_RST        = 16'd64;
	localparam logic [COUNT_BITS-1:0] COARSE_REVERSALS_RST = 8'd4;
	localparam logic [COUNT_BITS-1:0] FINE_REVERSALS_RST   = 8'd8;

	// Register indexes on the configuration port
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_COARSE_STEP      = 8'd0,
		REG_FINE_STEP        = 8'd1,
		REG_COARSE_REVERSALS = 8'd2,
		REG_FINE_REVERSALS   = 8'd3
	} cfg_reg_t;

endpackage

@@ design/stt_if.sv @@
// Valid/ready channel interfaces for trial words and result words.
// Depends on stt_pkg for the default stimulus width.

interface stt_trial_if #(parameter int STIMULUS_BITS = stt_pkg::STIMULUS_BITS_DEF);
	logic                     valid;
	logic                     ready;
	logic [STIMULUS_BITS-1:0] stimulus;
	logic                     answer;

	modport source (output valid, output stimulus, output answer, input ready);
	modport sink (input valid, input stimulus, input answer, output ready);
endinterface

interface stt_result_if #(parameter int STIMULUS_BITS = stt_pkg::STIMULUS_BITS_DEF);
	logic                     valid;
	logic                     ready;
	logic [STIMULUS_BITS-1:0] stim_next;
	logic                     finished;
	logic                     phase;
	logic [STIMULUS_BITS-1:0] estimate;
	logic                     estimate_valid;

	modport source (output valid, output stim_next, output finished, output phase,
		output estimate, output estimate_valid, input ready);
	modport sink (input valid, input stim_next, input finished, input phase,
		input estimate, input estimate_valid, output ready);
endinterface

@@ design/stt_div.sv @@
// Serial restoring divider: one quotient bit per cycle, 8-bit divisor.
// Depends on stt_pkg for the counter width.
module stt_div #(
	parameter int DIVIDEND_BITS = stt_pkg::STIMULUS_BITS_DEF + stt_pkg::COUNT_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [DIVIDEND_BITS-1:0]            dividend,
	input  logic [stt_pkg::COUNT_BITS-1:0]      divisor,
	output logic                                busy,
	output logic [DIVIDEND_BITS-1:0]            quotient
);

	localparam int DW       = stt_pkg::COUNT_BITS;
	localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

	logic                     busy_q;
	logic [CNT_BITS-1:0]      cnt_q;
	logic [DW-1:0]            rem_q;
	logic [DW-1:0]            dvs_q;
	logic [DIVIDEND_BITS-1:0] quo_q;

	logic [DW:0] rem_try;
	logic        fits;
	logic [DW:0] rem_sub;

	// Shift in the next dividend bit and trial-subtract the divisor
	always_comb begin
		rem_try = {rem_q, quo_q[DIVIDEND_BITS-1]};
		fits    = rem_try >= {1'b0, dvs_q};
		rem_sub = fits ? (rem_try - {1'b0, dvs_q}) : rem_try;
	end

	// Load on start, then advance one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(DIVIDEND_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_sub[DW-1:0];
			quo_q <= {quo_q[DIVIDEND_BITS-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider not busy after start");
	a_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("divider busy with empty bit count");
	a_fell_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> cnt_q == '0)
		else $error("divider stopped before last bit");

endmodule

@@ design/two_phase_staircase_tracker.sv @@
// Top level of the two-phase adaptive up/down staircase tracker.
// Depends on stt_pkg, stt_trial_if, stt_result_if and stt_div.
//
// Usage:
//   trial  (sink)  : one word per trial, the stimulus shown and the binary answer.
//   result (source): one word per trial: next stimulus, finished, phase,
//                    estimate and estimate_valid.
//   cfg_write/cfg_index/cfg_data: write coarse_step (0), fine_step (1),
//                    coarse_reversals (2), fine_reversals (3) while idle;
//                    other indexes are ignored.
// Timing: one trial word is in flight at a time; trial.ready is low from the
//   accept until its result word is loaded into the output register.
//   A normal trial is evaluated in ST_EVAL, and its result is loaded into the
//   output register as that state is left. The trial that ends the run runs
//   the mean through the serial divider, one quotient bit per cycle, in
//   ST_DIV, and its result is loaded from ST_FINAL. Trials after the end
//   return the held result.
// A result word waits in the output register while result.ready is low; the
//   next trial is still taken, and its result is held back until the
//   register frees.
// Reset clears the run and restores the register defaults (256, 64, 4, 8).
module two_phase_staircase_tracker #(
	parameter int STIMULUS_BITS = stt_pkg::STIMULUS_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [stt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [stt_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	stt_trial_if.sink                            trial,
	stt_result_if.source                         result
);

	localparam int CB       = stt_pkg::COUNT_BITS;
	localparam int SB       = stt_pkg::STEP_BITS;
	localparam int SUM_BITS = STIMULUS_BITS + CB;
	localparam int AW       = ((STIMULUS_BITS > SB) ? STIMULUS_BITS : SB) + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_FINAL
	} state_t;

	// Configuration registers
	logic [SB-1:0] coarse_step_q;
	logic [SB-1:0] fine_step_q;
	logic [CB-1:0] coarse_rev_q;
	logic [CB-1:0] fine_rev_q;

	// Run state
	state_t                   state_q;
	logic                     seen_q;
	logic                     last_q;
	logic                     phase_q;
	logic [CB-1:0]            rcount_q;
	logic [SUM_BITS-1:0]      sum_q;
	logic [CB-1:0]            coll_q;
	logic                     done_q;
	logic [STIMULUS_BITS-1:0] held_q;

	// Captured trial word
	logic [STIMULUS_BITS-1:0] stim_q;
	logic                     ans_q;

	// Output register
	logic                     out_valid_q;
	logic [STIMULUS_BITS-1:0] out_next_q;
	logic                     out_finished_q;
	logic                     out_phase_q;
	logic [STIMULUS_BITS-1:0] out_estimate_q;
	logic                     out_est_valid_q;

	// Trial evaluation
	logic                     rev;
	logic [CB-1:0]            nxt_count;
	logic                     phase_n;
	logic [CB-1:0]            rcount_n;
	logic [SUM_BITS-1:0]      sum_n;
	logic [CB-1:0]            coll_n;
	logic                     done_n;
	logic [SB-1:0]            step;
	logic [AW-1:0]            stim_x;
	logic [AW-1:0]            addend;
	logic [AW-1:0]            adder;
	logic [STIMULUS_BITS-1:0] next_stim;

	logic                     out_free;
	logic                     out_load;
	logic                     div_start;
	logic                     div_busy;
	logic [SUM_BITS-1:0]      div_quotient;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coarse_step_q <= stt_pkg::COARSE_STEP_RST;
			fine_step_q   <= stt_pkg::FINE_STEP_RST;
			coarse_rev_q  <= stt_pkg::COARSE_REVERSALS_RST;
			fine_rev_q    <= stt_pkg::FINE_REVERSALS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				stt_pkg::REG_COARSE_STEP:      coarse_step_q <= cfg_data[SB-1:0];
				stt_pkg::REG_FINE_STEP:        fine_step_q   <= cfg_data[SB-1:0];
				stt_pkg::REG_COARSE_REVERSALS: coarse_rev_q  <= cfg_data[CB-1:0];
				stt_pkg::REG_FINE_REVERSALS:   fine_rev_q    <= cfg_data[CB-1:0];
				default: begin
				end
			endcase
		end
	end

	// Detect a reversal and work out the run state after this trial
	always_comb begin
		rev       = seen_q && (last_q != ans_q);
		nxt_count = rcount_q + 1'b1;
		phase_n   = phase_q;
		rcount_n  = rcount_q;
		sum_n     = sum_q;
		coll_n    = coll_q;
		done_n    = done_q;
		if (rev) begin
			if (!phase_q) begin
				if (nxt_count == coarse_rev_q) begin
					phase_n  = 1'b1;
					rcount_n = '0;
				end else begin
					rcount_n = nxt_count;
				end
			end else begin
				// Collect a reversal when the reversal count is nonzero, until the collected count saturates
				if (rcount_q != '0 && coll_q != '1) begin
					sum_n  = sum_q + SUM_BITS'(stim_q);
					coll_n = coll_q + 1'b1;
				end
				if (nxt_count == fine_rev_q) begin
					done_n = 1'b1;
				end else begin
					rcount_n = nxt_count;
				end
			end
		end
	end

	// Step the stimulus with one adder: add on answer 1, subtract on answer 0
	always_comb begin
		step   = phase_n ? fine_step_q : coarse_step_q;
		stim_x = AW'(stim_q);
		addend = ans_q ? AW'(step) : ~AW'(step);
		adder  = stim_x + addend + AW'(!ans_q);
		if (ans_q) begin
			next_stim = (|adder[AW-1:STIMULUS_BITS]) ? '1 : adder[STIMULUS_BITS-1:0];
		end else begin
			next_stim = adder[AW-1] ? '0 : adder[STIMULUS_BITS-1:0];
		end
	end

	assign out_free  = !out_valid_q || result.ready;
	assign div_start = (state_q == ST_EVAL) && out_free && !done_q && done_n;
	assign out_load  = out_free && (((state_q == ST_EVAL) && (done_q || !done_n)) ||
		(state_q == ST_FINAL));

	stt_div #(
		.DIVIDEND_BITS (SUM_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_n),
		.divisor  (coll_n),
		.busy     (div_busy),
		.quotient (div_quotient)
	);

	// Sequence one trial: capture, evaluate, divide at the end, load the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seen_q      <= 1'b0;
			last_q      <= 1'b0;
			phase_q     <= 1'b0;
			rcount_q    <= '0;
			sum_q       <= '0;
			coll_q      <= '0;
			done_q      <= 1'b0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a result word, or hold the waiting one until it is taken
			out_valid_q <= out_load || (out_valid_q && !result.ready);
			case (state_q)
				ST_IDLE: begin
					if (trial.valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (out_free) begin
						if (done_q) begin
							state_q <= ST_IDLE;
						end else begin
							seen_q   <= 1'b1;
							last_q   <= ans_q;
							phase_q  <= phase_n;
							rcount_q <= rcount_n;
							sum_q    <= sum_n;
							coll_q   <= coll_n;
							done_q   <= done_n;
							if (done_n) begin
								state_q <= ST_DIV;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_DIV: begin
					if (!div_busy) begin
						held_q  <= (coll_q != '0) ? div_quotient[STIMULUS_BITS-1:0] : '0;
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the trial word and fill the result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && trial.valid) begin
			stim_q <= trial.stimulus;
			ans_q  <= trial.answer;
		end
		if (out_free) begin
			if ((state_q == ST_EVAL && done_q) || state_q == ST_FINAL) begin
				out_next_q      <= '0;
				out_finished_q  <= 1'b1;
				out_phase_q     <= phase_q;
				out_estimate_q  <= held_q;
				out_est_valid_q <= coll_q != '0;
			end else if (state_q == ST_EVAL) begin
				out_next_q      <= next_stim;
				out_finished_q  <= 1'b0;
				out_phase_q     <= phase_n;
				out_estimate_q  <= '0;
				out_est_valid_q <= 1'b0;
			end
		end
	end

	assign trial.ready           = (state_q == ST_IDLE);
	assign result.valid          = out_valid_q;
	assign result.stim_next      = out_next_q;
	assign result.finished       = out_finished_q;
	assign result.phase          = out_phase_q;
	assign result.estimate       = out_estimate_q;
	assign result.estimate_valid = out_est_valid_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		trial.valid && trial.ready |=> !trial.ready)
		else $error("second trial taken while one is in flight");
	a_done_fine: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> phase_q)
		else $error("run ended outside the fine phase");
	a_collect_fine: assert property (@(posedge clk) disable iff (!arst_n)
		coll_q != '0 |-> phase_q)
		else $error("stimulus collected in the coarse phase");
	a_active_no_est: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.finished |-> result.estimate == '0 && !result.estimate_valid)
		else $error("estimate shown before the run ended");

endmodule

@@ tb/sv/tb_two_phase_staircase_tracker.sv @@
// Self-checking testbench for the two-phase staircase tracker.
// Drives trial words, predicts each result word and checks it field by field.
// Depends on stt_pkg, the stt_trial_if/stt_result_if channels and the tracker top level.
module tb_two_phase_staircase_tracker;

	localparam int STIM_BITS     = stt_pkg::STIMULUS_BITS_DEF;
	localparam int LONG_HOLD     = 400;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [STIM_BITS-1:0] stimulus;
		logic                 answer;
	} trial_word_t;

	typedef struct packed {
		logic [STIM_BITS-1:0] stim_next;
		logic                 finished;
		logic                 phase;
		logic [STIM_BITS-1:0] estimate;
		logic                 estimate_valid;
	} result_word_t;

	typedef struct packed {
		logic                           seen_first;
		logic                           last_answer;
		logic                           fine_phase;
		logic [stt_pkg::COUNT_BITS-1:0] rev_count;
		logic [STIM_BITS+7:0]           rev_sum;
		logic [stt_pkg::COUNT_BITS-1:0] n_collected;
		logic                           run_done;
		logic [STIM_BITS-1:0]           held_mean;
	} tracker_state_t;

	typedef struct packed {
		logic [stt_pkg::STEP_BITS-1:0]  coarse_step;
		logic [stt_pkg::STEP_BITS-1:0]  fine_step;
		logic [stt_pkg::COUNT_BITS-1:0] coarse_reversals;
		logic [stt_pkg::COUNT_BITS-1:0] fine_reversals;
	} tracker_regs_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b1;
	logic                               cfg_write = 1'b0;
	logic [stt_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [stt_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

	stt_trial_if  #(.STIMULUS_BITS(STIM_BITS)) trial_ch ();
	stt_result_if #(.STIMULUS_BITS(STIM_BITS)) result_ch ();

	two_phase_staircase_tracker #(.STIMULUS_BITS(STIM_BITS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.trial     (trial_ch),
		.result    (result_ch)
	);

	// Register copy shared by the stimulus planner and the checker; it only
	// changes while the block is idle.
	tracker_regs_t  tracker_regs;
	tracker_state_t plan_state = '0;
	tracker_state_t check_state = '0;
	logic [STIM_BITS-1:0] plan_next = '0;

	trial_word_t  trials_to_send[$];
	result_word_t results_due[$];
	trial_word_t  sent_word;
	result_word_t due_word;

	int  send_gap;
	int  recv_gap;
	int  hold_left;
	bit  hold_taken;
	bit  hold_request = 1'b0;
	bit  calm_batch = 1'b0;
	int  n_trials;
	int  n_results;
	int  n_cfg_writes = 0;
	int  n_errors = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Advance the staircase by one trial and return the word it produces.
	function automatic result_word_t staircase_step(inout tracker_state_t st,
		input trial_word_t tw);
		result_word_t                            r;
		logic [stt_pkg::COUNT_BITS-1:0]          nxt;
		logic [stt_pkg::STEP_BITS-1:0]           step;
		logic [STIM_BITS+stt_pkg::STEP_BITS-1:0] up_sum;
		r = '0;
		if (!st.run_done) begin
			if (st.seen_first && st.last_answer != tw.answer) begin
				nxt = st.rev_count + 1'b1;
				if (!st.fine_phase) begin
					if (nxt == tracker_regs.coarse_reversals) begin
						st.fine_phase = 1'b1;
						st.rev_count  = '0;
					end else begin
						st.rev_count = nxt;
					end
				end else begin
					// The first fine reversal is not collected; stop at a full count
					if (st.rev_count != 0 && st.n_collected != '1) begin
						st.rev_sum     = st.rev_sum + tw.stimulus;
						st.n_collected = st.n_collected + 1'b1;
					end
					if (nxt == tracker_regs.fine_reversals) begin
						st.run_done  = 1'b1;
						st.held_mean = (st.n_collected != 0) ?
							STIM_BITS'(st.rev_sum / st.n_collected) : '0;
					end else begin
						st.rev_count = nxt;
					end
				end
			end
			st.seen_first  = 1'b1;
			st.last_answer = tw.answer;
		end
		r.phase = st.fine_phase;
		if (st.run_done) begin
			r.finished       = 1'b1;
			r.estimate       = st.held_mean;
			r.estimate_valid = (st.n_collected != 0);
		end else begin
			step = st.fine_phase ? tracker_regs.fine_step : tracker_regs.coarse_step;
			if (!tw.answer) begin
				r.stim_next = (tw.stimulus >= step) ? tw.stimulus - step : '0;
			end else begin
				up_sum = tw.stimulus + step;
				r.stim_next = (up_sum > {STIM_BITS{1'b1}}) ? '1 : up_sum[STIM_BITS-1:0];
			end
		end
		return r;
	endfunction

	// Mostly back-to-back, some short pauses, a few long ones.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm_batch || roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [stt_pkg::STEP_BITS-1:0] pick_step();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2, 3: return stt_pkg::STEP_BITS'($urandom_range(1, 16'h0400));
			default: return stt_pkg::STEP_BITS'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// Offer trial words, hold each until taken, then predict its result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trial_ch.valid    <= 1'b0;
			trial_ch.stimulus <= '0;
			trial_ch.answer   <= 1'b0;
			send_gap          <= 0;
			n_trials          <= 0;
		end else if (!trial_ch.valid || trial_ch.ready) begin
			if (trial_ch.valid) begin
				sent_word.stimulus = trial_ch.stimulus;
				sent_word.answer   = trial_ch.answer;
				results_due.insert(results_due.size(), staircase_step(check_state, sent_word));
				n_trials <= n_trials + 1;
			end
			if (send_gap != 0) begin
				send_gap       <= send_gap - 1;
				trial_ch.valid <= 1'b0;
			end else if (trials_to_send.size() != 0) begin
				sent_word = trials_to_send.pop_front();
				trial_ch.stimulus <= sent_word.stimulus;
				trial_ch.answer   <= sent_word.answer;
				trial_ch.valid    <= 1'b1;
				send_gap          <= pick_gap();
			end else begin
				trial_ch.valid <= 1'b0;
			end
		end
	end

	// Count down the long receiver hold-off once it is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_taken <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_taken) begin
			hold_left  <= LONG_HOLD;
			hold_taken <= 1'b1;
		end
	end

	// Take result words and compare them with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			recv_gap        <= 0;
			n_results       <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				n_results <= n_results + 1;
				if (results_due.size() == 0) begin
					$error("result word with no trial outstanding");
					n_errors++;
				end else begin
					due_word = results_due.pop_front();
					if (result_ch.stim_next !== due_word.stim_next) begin
						$error("stim_next: expected %h, got %h",
							due_word.stim_next, result_ch.stim_next);
						n_errors++;
					end
					if (result_ch.finished !== due_word.finished) begin
						$error("finished: expected %b, got %b",
							due_word.finished, result_ch.finished);
						n_errors++;
					end
					if (result_ch.phase !== due_word.phase) begin
						$error("phase: expected %b, got %b", due_word.phase, result_ch.phase);
						n_errors++;
					end
					if (result_ch.estimate !== due_word.estimate) begin
						$error("estimate: expected %h, got %h",
							due_word.estimate, result_ch.estimate);
						n_errors++;
					end
					if (result_ch.estimate_valid !== due_word.estimate_valid) begin
						$error("estimate_valid: expected %b, got %b",
							due_word.estimate_valid, result_ch.estimate_valid);
						n_errors++;
					end
				end
			end
			if (hold_left != 0) begin
				result_ch.ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap        <= recv_gap - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				recv_gap        <= pick_gap();
			end
		end
	end

	// Wait until every word is sent and every result has come back.
	task automatic drain();
		do
			@(negedge clk);
		while (trials_to_send.size() != 0 || trial_ch.valid || results_due.size() != 0);
	endtask

	task automatic write_reg(input logic [stt_pkg::CFG_INDEX_BITS-1:0] idx,
		input logic [stt_pkg::CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			stt_pkg::REG_COARSE_STEP:      tracker_regs.coarse_step      = val;
			stt_pkg::REG_FINE_STEP:        tracker_regs.fine_step        = val;
			stt_pkg::REG_COARSE_REVERSALS:
				tracker_regs.coarse_reversals = val[stt_pkg::COUNT_BITS-1:0];
			stt_pkg::REG_FINE_REVERSALS:
				tracker_regs.fine_reversals   = val[stt_pkg::COUNT_BITS-1:0];
			default: ;
		endcase
		n_cfg_writes++;
		@(negedge clk);
	endtask

	task automatic queue_trial(input logic [STIM_BITS-1:0] stim, input logic ans);
		trial_word_t  tw;
		result_word_t r;
		tw.stimulus = stim;
		tw.answer   = ans;
		r = staircase_step(plan_state, tw);
		plan_next = r.stim_next;
		trials_to_send.insert(trials_to_send.size(), tw);
	endtask

	// One burst of trials, with the step sizes sometimes rewritten, at a random reversal rate.
	task automatic random_batch();
		int                   flip_pct;
		logic                 ans;
		logic [STIM_BITS-1:0] stim;
		drain();
		if ($urandom_range(0, 1))
			write_reg(stt_pkg::REG_COARSE_STEP, pick_step());
		if ($urandom_range(0, 1))
			write_reg(stt_pkg::REG_FINE_STEP, pick_step());
		if ($urandom_range(0, 9) == 0)
			write_reg(stt_pkg::CFG_INDEX_BITS'($urandom_range(4, 255)),
				stt_pkg::CFG_DATA_BITS'($urandom_range(0, 16'hFFFF)));
		calm_batch = ($urandom_range(0, 4) == 0);
		case ($urandom_range(0, 3))
			0: flip_pct = 10;
			1: flip_pct = 25;
			2: flip_pct = 50;
			default: flip_pct = 85;
		endcase
		repeat ($urandom_range(20, 40)) begin
			ans = plan_state.last_answer ^ ($urandom_range(1, 100) <= flip_pct);
			// Follow the staircase most of the time, jump around otherwise
			if (plan_state.run_done || $urandom_range(1, 100) <= 30) begin
				case ($urandom_range(0, 3))
					0: stim = '0;
					1: stim = '1;
					default: stim = STIM_BITS'($urandom_range(0, 16'hFFFF));
				endcase
			end else begin
				stim = plan_next;
			end
			queue_trial(stim, ans);
		end
	endtask

	initial begin
		tracker_regs.coarse_step      = stt_pkg::COARSE_STEP_RST;
		tracker_regs.fine_step        = stt_pkg::FINE_STEP_RST;
		tracker_regs.coarse_reversals = stt_pkg::COARSE_REVERSALS_RST;
		tracker_regs.fine_reversals   = stt_pkg::FINE_REVERSALS_RST;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// First trial under the reset step, clamped at zero
		queue_trial(16'h0000, 1'b0);
		queue_trial(16'h0000, 1'b0);
		drain();
		// Zero limits act as 256 and keep the run going
		write_reg(stt_pkg::REG_COARSE_REVERSALS, '0);
		write_reg(stt_pkg::REG_FINE_REVERSALS, '0);
		write_reg(stt_pkg::REG_COARSE_STEP, '1);
		queue_trial(16'h1234, 1'b1);
		queue_trial(16'hFFFF, 1'b1);
		queue_trial(16'h8000, 1'b0);
		drain();
		write_reg(stt_pkg::REG_COARSE_STEP, '0);
		queue_trial(16'h5555, 1'b0);
		queue_trial(16'hAAAA, 1'b1);
		drain();
		write_reg(stt_pkg::REG_COARSE_STEP, 16'h0001);
		write_reg(stt_pkg::CFG_INDEX_BITS'($urandom_range(4, 255)), 16'hFFFF);
		queue_trial(16'h0000, 1'b1);
		queue_trial(16'hFFFE, 1'b1);
		queue_trial(16'hFFFF, 1'b1);
		queue_trial(16'h0001, 1'b0);
		queue_trial(16'h0000, 1'b0);
		drain();

		// Coarse phase: long stretch, then a limit below the count forces a wrap
		write_reg(stt_pkg::REG_COARSE_REVERSALS, 16'd255);
		while (plan_state.rev_count < 150 && !plan_state.fine_phase)
			random_batch();
		drain();
		write_reg(stt_pkg::REG_COARSE_REVERSALS, 16'd1);
		while (!plan_state.fine_phase)
			random_batch();
		drain();

		// Fine phase: fill the receiver once, then collect past a full count
		write_reg(stt_pkg::REG_FINE_REVERSALS, 16'd255);
		random_batch();
		hold_request = 1'b1;
		while (plan_state.rev_count < 200 && !plan_state.run_done)
			random_batch();
		drain();
		write_reg(stt_pkg::REG_FINE_REVERSALS, stt_pkg::CFG_DATA_BITS'($urandom_range(2, 120)));
		while (!plan_state.run_done)
			random_batch();

		// Finished: every further trial repeats the held result
		repeat (4) random_batch();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (results_due.size() != 0) begin
			$error("%0d predicted result words never arrived", results_due.size());
			n_errors++;
		end
		$display("Ran %0d trial words and %0d result words with %0d register writes.",
			n_trials, n_results, n_cfg_writes);
		$display("Run ended with %0d collected reversal stimuli, mean %h.",
			check_state.n_collected, check_state.held_mean);
		if (n_errors == 0) begin
			$display("tb_two_phase_staircase_tracker: PASS");
		end else begin
			$display("tb_two_phase_staircase_tracker: FAIL");
		end
		$finish;
	end

	// Stop a run that hangs
	initial begin
		#1600000;
		$display("tb_two_phase_staircase_tracker: FAIL");
		$finish;
	end

endmodule

@@ two_phase_staircase_tracker.f @@
design/stt_pkg.sv
design/stt_if.sv
design/stt_div.sv
design/two_phase_staircase_tracker.sv
tb/sv/tb_two_phase_staircase_tracker.sv
